// ===== rtl/refcounted_page_allocator_defines.svh =====
// Assertion helpers for the checker file rcpa_checker.sv.
// All of them sample on clk and are switched off while arst_n is low.
`ifndef REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_PAGE_ALLOCATOR_DEFINES_SVH

// Plain property check.
`define RCPA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// Condition that must never be seen.
`define RCPA_ASSERT_NEVER(lbl, cond, msg) \
	`RCPA_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/rcpa_pkg.sv =====
package rcpa_pkg;

	// Sizing
	localparam int NUM_PAGES  = 16384;
	localparam int COUNT_BITS = 8;
	localparam int ADDR_W     = $clog2(NUM_PAGES);
	localparam int DEPTH_W    = $clog2(NUM_PAGES + 1);

	// Field widths
	localparam int FUNC_W     = 3;
	localparam int PAGE_W     = 14;
	localparam int OUT_CNT_W  = 8;
	localparam int STATUS_W   = 2;
	localparam int KEND_W     = 14;
	localparam int PTOP_W     = 15;
	localparam int CFG_DATA_W = 15;
	localparam int CFG_IDX_W  = 1;

	localparam logic [PTOP_W-1:0]     PTOP_RESET = PTOP_W'(16384);
	localparam logic [COUNT_BITS-1:0] CNT_MAX    = {COUNT_BITS{1'b1}};

	typedef enum logic [FUNC_W-1:0] {
		FN_INIT_FREE = 3'd0,
		FN_FREE      = 3'd1,
		FN_ALLOC     = 3'd2,
		FN_INC       = 3'd3,
		FN_DEC       = 3'd4,
		FN_QUERY     = 3'd5
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_BAD   = 2'd2
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KERNEL_END = 1'b0,
		REG_PHYS_TOP   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC
	} state_t;

	// Controller -> datapath
	typedef struct packed {
		logic clr_en;
		logic accept;
		logic exec;
	} ctrl_cmd_t;

	// Datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic out_stall;
	} dp_status_t;

endpackage

// ===== rtl/rcpa_if.sv =====
// Request channel: one operation per beat.
interface rcpa_req_if;
	logic                          valid;
	logic                          ready;
	logic [rcpa_pkg::FUNC_W-1:0]   func;
	logic [rcpa_pkg::PAGE_W-1:0]   page;

	modport source(output valid, func, page, input ready);
	modport sink(input valid, func, page, output ready);
endinterface

// Response channel: one result per request.
interface rcpa_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [rcpa_pkg::PAGE_W-1:0]     page_out;
	logic [rcpa_pkg::OUT_CNT_W-1:0]  ref_count;
	logic [rcpa_pkg::STATUS_W-1:0]   status;

	modport source(output valid, page_out, ref_count, status, input ready);
	modport sink(input valid, page_out, ref_count, status, output ready);
endinterface

// ===== rtl/rcpa_ram.sv =====
// Simple dual-port RAM: one write port, one read port, registered read.
module rcpa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/rcpa_ctrl.sv =====
// Sequencer: clearing pass after reset, then accept / execute per request.
module rcpa_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  rcpa_pkg::dp_status_t   dp_stat,
	output rcpa_pkg::ctrl_cmd_t    cmd
);

	rcpa_pkg::state_t state_q, state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcpa_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rcpa_pkg::ST_CLEAR: begin
				if (dp_stat.clr_last) state_nxt = rcpa_pkg::ST_IDLE;
			end
			rcpa_pkg::ST_IDLE: begin
				if (req_valid) state_nxt = rcpa_pkg::ST_EXEC;
			end
			rcpa_pkg::ST_EXEC: begin
				if (!dp_stat.out_stall) state_nxt = rcpa_pkg::ST_IDLE;
			end
			default: state_nxt = rcpa_pkg::ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_ready  = 1'b0;
		cmd        = '0;
		unique case (state_q)
			rcpa_pkg::ST_CLEAR: begin
				cmd.clr_en = 1'b1;
			end
			rcpa_pkg::ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
			end
			rcpa_pkg::ST_EXEC: begin
				// commit only when the result register can take the beat
				cmd.exec = !dp_stat.out_stall;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/rcpa_dp.sv =====
// Datapath: count and stack memories, stack pointer, config and result registers.
module rcpa_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rcpa_pkg::ctrl_cmd_t               cmd,
	output rcpa_pkg::dp_status_t              dp_stat,
	input  logic [rcpa_pkg::FUNC_W-1:0]       func,
	input  logic [rcpa_pkg::PAGE_W-1:0]       page,
	input  logic                              cfg_we,
	input  logic [rcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcpa_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              out_ready,
	output logic                              out_valid,
	output logic [rcpa_pkg::PAGE_W-1:0]       out_page,
	output logic [rcpa_pkg::OUT_CNT_W-1:0]    out_count,
	output logic [rcpa_pkg::STATUS_W-1:0]     out_status
);

	localparam int AW = rcpa_pkg::ADDR_W;
	localparam int DW = rcpa_pkg::DEPTH_W;
	localparam int CW = rcpa_pkg::COUNT_BITS;
	localparam int PW = rcpa_pkg::PAGE_W;

	rcpa_pkg::func_t             func_q;
	logic [PW-1:0]               page_q;
	logic [DW-1:0]               depth_q;
	logic [AW-1:0]               clr_q;
	logic [rcpa_pkg::KEND_W-1:0] kend_q;
	logic [rcpa_pkg::PTOP_W-1:0] ptop_q;

	logic                        out_valid_q;
	logic [PW-1:0]               out_page_q;
	logic [rcpa_pkg::OUT_CNT_W-1:0] out_count_q;
	rcpa_pkg::status_t           out_status_q;

	logic [CW-1:0]               cnt_rd;
	logic [PW-1:0]               stk_rd;

	logic                        page_ok;
	logic                        rel_bad;
	logic                        stack_full;
	logic                        stack_empty;
	logic [CW-1:0]               cnt_cur;

	logic                        op_cnt_we;
	logic [AW-1:0]               op_cnt_waddr;
	logic [CW-1:0]               op_cnt_wdata;
	logic                        push;
	logic                        pop;
	logic [PW-1:0]               res_page;
	logic [CW-1:0]               res_cnt;
	rcpa_pkg::status_t           res_status;

	logic                        cnt_we;
	logic [AW-1:0]               cnt_waddr;
	logic [CW-1:0]               cnt_wdata;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kend_q <= '0;
			ptop_q <= rcpa_pkg::PTOP_RESET;
		end else if (cfg_we) begin
			unique case (rcpa_pkg::cfg_reg_t'(cfg_index))
				rcpa_pkg::REG_KERNEL_END: kend_q <= cfg_data[rcpa_pkg::KEND_W-1:0];
				rcpa_pkg::REG_PHYS_TOP:   ptop_q <= cfg_data[rcpa_pkg::PTOP_W-1:0];
				default: ;
			endcase
		end
	end

	// Request latch
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			func_q <= rcpa_pkg::func_t'(func);
			page_q <= page;
		end
	end

	// Clearing pass counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clr_en) begin
			clr_q <= clr_q + AW'(1);
		end
	end

	assign dp_stat.clr_last  = (clr_q == AW'(rcpa_pkg::NUM_PAGES - 1));
	assign dp_stat.out_stall = out_valid_q && !out_ready;

	// Stack pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (cmd.exec) begin
			if (push) depth_q <= depth_q + DW'(1);
			else if (pop) depth_q <= depth_q - DW'(1);
		end
	end

	// Bounds and stack checks
	assign page_ok     = (32'(page_q) < 32'(rcpa_pkg::NUM_PAGES));
	assign rel_bad     = (page_q < kend_q) || (rcpa_pkg::PTOP_W'(page_q) >= ptop_q) || !page_ok;
	assign stack_full  = (depth_q == DW'(rcpa_pkg::NUM_PAGES));
	assign stack_empty = (depth_q == '0);
	assign cnt_cur     = page_ok ? cnt_rd : '0;

	// Operation decode
	always_comb begin
		op_cnt_we    = 1'b0;
		op_cnt_waddr = AW'(page_q);
		op_cnt_wdata = '0;
		push         = 1'b0;
		pop          = 1'b0;
		res_page     = page_q;
		res_cnt      = cnt_cur;
		res_status   = rcpa_pkg::STAT_OK;
		unique case (func_q)
			rcpa_pkg::FN_INIT_FREE: begin
				op_cnt_we = page_ok;
				res_cnt   = '0;
				if (rel_bad) res_status = rcpa_pkg::STAT_BAD;
				else push = !stack_full;
			end
			rcpa_pkg::FN_FREE: begin
				if (page_ok && cnt_rd > CW'(1)) begin
					op_cnt_we    = 1'b1;
					op_cnt_wdata = cnt_rd - CW'(1);
					res_cnt      = cnt_rd - CW'(1);
				end else if (rel_bad) begin
					res_status = rcpa_pkg::STAT_BAD;
				end else begin
					push = !stack_full;
				end
			end
			rcpa_pkg::FN_ALLOC: begin
				if (stack_empty) begin
					res_status = rcpa_pkg::STAT_EMPTY;
					res_page   = '0;
					res_cnt    = '0;
				end else begin
					pop          = 1'b1;
					res_page     = stk_rd;
					op_cnt_we    = 1'b1;
					op_cnt_waddr = AW'(stk_rd);
					op_cnt_wdata = CW'(1);
					res_cnt      = CW'(1);
				end
			end
			rcpa_pkg::FN_INC: begin
				if (page_ok && cnt_rd != rcpa_pkg::CNT_MAX) begin
					op_cnt_we    = 1'b1;
					op_cnt_wdata = cnt_rd + CW'(1);
					res_cnt      = cnt_rd + CW'(1);
				end
			end
			rcpa_pkg::FN_DEC: begin
				if (page_ok && cnt_rd != '0) begin
					op_cnt_we    = 1'b1;
					op_cnt_wdata = cnt_rd - CW'(1);
					res_cnt      = cnt_rd - CW'(1);
				end
			end
			default: ;  // query and unused codes
		endcase
	end

	// Count memory write port: clearing pass or commit
	assign cnt_we    = cmd.clr_en || (cmd.exec && op_cnt_we);
	assign cnt_waddr = cmd.clr_en ? clr_q : op_cnt_waddr;
	assign cnt_wdata = cmd.clr_en ? '0 : op_cnt_wdata;

	rcpa_ram #(
		.WIDTH(CW),
		.DEPTH(rcpa_pkg::NUM_PAGES)
	) u_cnt_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cmd.accept),
		.raddr (AW'(page)),
		.rdata (cnt_rd)
	);

	// Free stack: push at depth, top of stack read at accept
	rcpa_ram #(
		.WIDTH(PW),
		.DEPTH(rcpa_pkg::NUM_PAGES)
	) u_stk_ram (
		.clk   (clk),
		.we    (cmd.exec && push),
		.waddr (AW'(depth_q)),
		.wdata (page_q),
		.re    (cmd.accept),
		.raddr (AW'(depth_q - DW'(1))),
		.rdata (stk_rd)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.exec) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			out_page_q   <= res_page;
			out_count_q  <= rcpa_pkg::OUT_CNT_W'(res_cnt);
			out_status_q <= res_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_page   = out_page_q;
	assign out_count  = out_count_q;
	assign out_status = out_status_q;

endmodule

// ===== rtl/refcounted_page_allocator.sv =====
// Channel  Dir  Beat contents
// req      in   func, page
// rsp      out  page_out, ref_count, status
// cfg      in   cfg_we, cfg_index, cfg_data (write only)
//
// Each request is latched in IDLE, where the count and free-stack memories
// are read; EXEC then writes back and loads the result register.
// After reset a clearing pass zeroes all NUM_PAGES (16384) count memory
// entries, one entry a cycle; req is not ready until it ends.
// A response held by rsp stalls the next request in its commit cycle.
module refcounted_page_allocator (
	input  logic                              clk,
	input  logic                              arst_n,
	rcpa_req_if.sink                          req,
	rcpa_rsp_if.source                        rsp,
	input  logic                              cfg_we,
	input  logic [rcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [rcpa_pkg::CFG_DATA_W-1:0]   cfg_data
);

	rcpa_pkg::ctrl_cmd_t  cmd;
	rcpa_pkg::dp_status_t dp_stat;

	rcpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.dp_stat   (dp_stat),
		.cmd       (cmd)
	);

	rcpa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.dp_stat    (dp_stat),
		.func       (req.func),
		.page       (req.page),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_ready  (rsp.ready),
		.out_valid  (rsp.valid),
		.out_page   (rsp.page_out),
		.out_count  (rsp.ref_count),
		.out_status (rsp.status)
	);

endmodule

// ===== rtl/rcpa_checker.sv =====
`include "refcounted_page_allocator_defines.svh"

// Port-level checks on the allocator.
module rcpa_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             req_valid,
	input logic                             req_ready,
	input logic                             rsp_valid,
	input logic                             rsp_ready,
	input logic [rcpa_pkg::PAGE_W-1:0]      rsp_page_out,
	input logic [rcpa_pkg::OUT_CNT_W-1:0]   rsp_ref_count,
	input logic [rcpa_pkg::STATUS_W-1:0]    rsp_status
);

	// one request in flight: no back-to-back accepts
	`RCPA_ASSERT(a_one_in_flight, (req_valid && req_ready) |=> !req_ready, "request accepted while busy")

	// an empty alloc reports page 0 and count 0
	`RCPA_ASSERT(a_empty_zero, (rsp_valid && rsp_status == rcpa_pkg::STAT_EMPTY) |-> (rsp_page_out == '0 && rsp_ref_count == '0), "empty alloc with nonzero fields")

	// no undefined status code
	`RCPA_ASSERT_NEVER(a_status_code, rsp_valid && rsp_status != rcpa_pkg::STAT_OK && rsp_status != rcpa_pkg::STAT_EMPTY && rsp_status != rcpa_pkg::STAT_BAD, "undefined status code")

	// a stalled response holds
	`RCPA_ASSERT(a_rsp_hold, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_page_out) && $stable(rsp_ref_count) && $stable(rsp_status)), "response changed under stall")

endmodule

bind refcounted_page_allocator rcpa_checker u_rcpa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_page_out  (rsp.page_out),
	.rsp_ref_count (rsp.ref_count),
	.rsp_status    (rsp.status)
);
